// ===== hw/rtl/rv32s_pkg.sv =====
package rv32s_pkg;

    localparam logic [6:0] OP_REG    = 7'h33;
    localparam logic [6:0] OP_IMM    = 7'h13;
    localparam logic [6:0] OP_JALR   = 7'h67;
    localparam logic [6:0] OP_LOAD   = 7'h03;
    localparam logic [6:0] OP_STORE  = 7'h23;
    localparam logic [6:0] OP_BRANCH = 7'h63;
    localparam logic [6:0] OP_AUIPC  = 7'h17;
    localparam logic [6:0] OP_JAL    = 7'h6F;

    localparam logic [31:0] EBREAK_WORD = 32'h0010_0073;
    localparam logic [4:0]  A0_INDEX    = 5'd10;
    localparam logic [6:0]  F7_ZERO     = 7'h00;
    localparam logic [6:0]  F7_ALT      = 7'h20;

    localparam logic [1:0] REQ_NONE  = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_WRITE = 2'd2;

    localparam logic [1:0] ST_NORMAL  = 2'd0;
    localparam logic [1:0] ST_HALT    = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef enum logic [4:0] {
        K_NOP    = 5'd0,
        K_ADD    = 5'd1,
        K_SUB    = 5'd2,
        K_SLL    = 5'd3,
        K_SLTU   = 5'd4,
        K_XOR    = 5'd5,
        K_SRA    = 5'd6,
        K_OR     = 5'd7,
        K_AND    = 5'd8,
        K_ADDI   = 5'd9,
        K_SLTIU  = 5'd10,
        K_SRAI   = 5'd11,
        K_XORI   = 5'd12,
        K_ANDI   = 5'd13,
        K_JALR   = 5'd14,
        K_LW     = 5'd15,
        K_LBU    = 5'd16,
        K_SB     = 5'd17,
        K_SH     = 5'd18,
        K_SW     = 5'd19,
        K_BEQ    = 5'd20,
        K_BNE    = 5'd21,
        K_AUIPC  = 5'd22,
        K_JAL    = 5'd23,
        K_EBREAK = 5'd24,
        K_BAD    = 5'd25,
        K_LDRET  = 5'd26
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [4:0]  rd;
        logic [4:0]  rs1;
        logic [4:0]  rs2;
        logic [31:0] imm;
        logic [31:0] pc;
        logic [31:0] load_data;
    } uop_t;

    typedef struct packed {
        logic [31:0] next_pc;
        logic [1:0]  mem_request;
        logic [31:0] mem_address;
        logic [2:0]  mem_bytes;
        logic [31:0] mem_write_data;
        logic [1:0]  status;
        logic [31:0] exit_code;
    } result_t;

endpackage

// ===== hw/rtl/rv32s_decode.sv =====
module rv32s_decode (
    input  logic                  func,
    input  logic [31:0]           instruction,
    input  logic [31:0]           pc,
    input  logic [31:0]           load_data,
    output rv32s_pkg::uop_t       uop
);
    import rv32s_pkg::*;

    logic [6:0]  op;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [31:0] imm_i;
    logic [31:0] imm_s;
    logic [31:0] imm_b;
    logic [31:0] imm_j;
    logic [31:0] imm_u;
    kind_t       kind;
    logic [31:0] imm;

    assign op    = instruction[6:0];
    assign f3    = instruction[14:12];
    assign f7    = instruction[31:25];
    assign imm_i = {{20{instruction[31]}}, instruction[31:20]};
    assign imm_s = {{20{instruction[31]}}, instruction[31:25], instruction[11:7]};
    assign imm_b = {{19{instruction[31]}}, instruction[31], instruction[7],
                    instruction[30:25], instruction[11:8], 1'b0};
    assign imm_j = {{11{instruction[31]}}, instruction[31], instruction[19:12],
                    instruction[20], instruction[30:21], 1'b0};
    assign imm_u = {instruction[31:12], 12'h000};

    always_comb
    begin
        kind = K_BAD;
        imm  = imm_i;
        if (func)
        begin
            kind = K_LDRET;
        end
        else if (op == OP_REG && f7 == F7_ZERO)
        begin
            unique case (f3)
                3'd0:    kind = K_ADD;
                3'd1:    kind = K_SLL;
                3'd3:    kind = K_SLTU;
                3'd4:    kind = K_XOR;
                3'd6:    kind = K_OR;
                3'd7:    kind = K_AND;
                default: kind = K_BAD;
            endcase
        end
        else if (op == OP_REG && f7 == F7_ALT && f3 == 3'd0)
            kind = K_SUB;
        else if (op == OP_REG && f7 == F7_ALT && f3 == 3'd5)
            kind = K_SRA;
        else if (op == OP_IMM && f3 == 3'd0)
            kind = K_ADDI;
        else if (op == OP_IMM && f3 == 3'd3)
            kind = K_SLTIU;
        else if (op == OP_IMM && f3 == 3'd5 && f7 == F7_ALT)
            kind = K_SRAI;
        else if (op == OP_IMM && f3 == 3'd4)
            kind = K_XORI;
        else if (op == OP_IMM && f3 == 3'd7)
            kind = K_ANDI;
        else if (op == OP_JALR && f3 == 3'd0)
            kind = K_JALR;
        else if (op == OP_LOAD && f3 == 3'd2)
            kind = K_LW;
        else if (op == OP_LOAD && f3 == 3'd4)
            kind = K_LBU;
        else if (op == OP_STORE && f3 <= 3'd2)
        begin
            imm = imm_s;
            unique case (f3)
                3'd0:    kind = K_SB;
                3'd1:    kind = K_SH;
                default: kind = K_SW;
            endcase
        end
        else if (op == OP_BRANCH && f3 == 3'd0)
        begin
            kind = K_BEQ;
            imm  = imm_b;
        end
        else if (op == OP_BRANCH && f3 == 3'd1)
        begin
            kind = K_BNE;
            imm  = imm_b;
        end
        else if (op == OP_AUIPC)
        begin
            kind = K_AUIPC;
            imm  = imm_u;
        end
        else if (op == OP_JAL)
        begin
            kind = K_JAL;
            imm  = imm_j;
        end
        else if (instruction == EBREAK_WORD)
            kind = K_EBREAK;
    end

    always_comb
    begin
        uop.kind      = kind;
        uop.rd        = instruction[11:7];
        uop.rs1       = instruction[19:15];
        uop.rs2       = (kind == K_EBREAK) ? A0_INDEX : instruction[24:20];
        uop.imm       = imm;
        uop.pc        = pc;
        uop.load_data = load_data;
    end

endmodule

// ===== hw/rtl/rv32s_queue.sv =====
module rv32s_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  rv32s_pkg::uop_t   in_uop,
    output logic              out_valid,
    input  logic              out_ready,
    output rv32s_pkg::uop_t   out_uop
);
    import rv32s_pkg::*;

    uop_t                 mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]    wptr_reg;
    logic [QPTR_W-1:0]    rptr_reg;
    logic [QPTR_W:0]      count_reg;
    logic                 push;
    logic                 pop;

    assign in_ready  = (count_reg != QUEUE_DEPTH[QPTR_W:0]);
    assign out_valid = (count_reg != '0);
    assign out_uop   = mem_reg[rptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wptr_reg] <= in_uop;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
                wptr_reg <= wptr_reg + 1'b1;
            if (pop)
                rptr_reg <= rptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QUEUE_DEPTH[QPTR_W:0])
        else $error("queue count overflow");
    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wptr_reg == rptr_reg))
        else $error("empty queue pointers disagree");
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == QUEUE_DEPTH[QPTR_W:0]) |=> (count_reg != '0))
        else $error("full queue drained at once");
`endif

endmodule

// ===== hw/rtl/rv32s_execute.sv =====
module rv32s_execute (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  rv32s_pkg::uop_t   in_uop,
    output logic              out_valid,
    input  logic              out_ready,
    output rv32s_pkg::result_t out_res
);
    import rv32s_pkg::*;

    logic [31:0] rf_reg [32];
    logic [4:0]  pend_rd_reg;
    logic        pend_byte_reg;
    logic        out_valid_reg;
    result_t     out_reg;

    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] pc4;
    logic [31:0] sum_ai;
    logic [31:0] r;
    logic        wen;
    logic [4:0]  wrd;
    result_t     res;
    logic        fire;

    assign in_ready  = !out_valid_reg || out_ready;
    assign fire      = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;

    assign a      = rf_reg[in_uop.rs1];
    assign b      = rf_reg[in_uop.rs2];
    assign pc4    = in_uop.pc + 32'd4;
    assign sum_ai = a + in_uop.imm;

    always_comb
    begin
        res            = '0;
        res.next_pc    = pc4;
        r              = '0;
        wen            = 1'b0;
        wrd            = in_uop.rd;
        case (in_uop.kind)
            K_ADD:   begin r = a + b; wen = 1'b1; end
            K_SUB:   begin r = a - b; wen = 1'b1; end
            K_SLL:   begin r = a << b[4:0]; wen = 1'b1; end
            K_SLTU:  begin r = {31'd0, a < b}; wen = 1'b1; end
            K_XOR:   begin r = a ^ b; wen = 1'b1; end
            K_SRA:   begin r = $unsigned($signed(a) >>> b[4:0]); wen = 1'b1; end
            K_OR:    begin r = a | b; wen = 1'b1; end
            K_AND:   begin r = a & b; wen = 1'b1; end
            K_ADDI:  begin r = sum_ai; wen = 1'b1; end
            K_SLTIU: begin r = {31'd0, a < in_uop.imm}; wen = 1'b1; end
            K_SRAI:  begin r = $unsigned($signed(a) >>> in_uop.imm[4:0]); wen = 1'b1; end
            K_XORI:  begin r = a ^ in_uop.imm; wen = 1'b1; end
            K_ANDI:  begin r = a & in_uop.imm; wen = 1'b1; end
            K_JALR:
            begin
                res.next_pc = {sum_ai[31:1], 1'b0};
                r   = pc4;
                wen = 1'b1;
            end
            K_LW, K_LBU:
            begin
                res.mem_request = REQ_READ;
                res.mem_address = sum_ai;
                res.mem_bytes   = (in_uop.kind == K_LW) ? 3'd4 : 3'd1;
            end
            K_SB:
            begin
                res.mem_request    = REQ_WRITE;
                res.mem_address    = sum_ai;
                res.mem_bytes      = 3'd1;
                res.mem_write_data = {24'd0, b[7:0]};
            end
            K_SH:
            begin
                res.mem_request    = REQ_WRITE;
                res.mem_address    = sum_ai;
                res.mem_bytes      = 3'd2;
                res.mem_write_data = {16'd0, b[15:0]};
            end
            K_SW:
            begin
                res.mem_request    = REQ_WRITE;
                res.mem_address    = sum_ai;
                res.mem_bytes      = 3'd4;
                res.mem_write_data = b;
            end
            K_BEQ:   if (a == b) res.next_pc = in_uop.pc + in_uop.imm;
            K_BNE:   if (a != b) res.next_pc = in_uop.pc + in_uop.imm;
            K_AUIPC: begin r = in_uop.pc + in_uop.imm; wen = 1'b1; end
            K_JAL:
            begin
                res.next_pc = in_uop.pc + in_uop.imm;
                r   = pc4;
                wen = 1'b1;
            end
            K_EBREAK:
            begin
                res.status    = ST_HALT;
                res.exit_code = b;
            end
            K_LDRET:
            begin
                res = '0;
                wrd = pend_rd_reg;
                wen = 1'b1;
                r   = pend_byte_reg ? {24'd0, in_uop.load_data[7:0]} : in_uop.load_data;
            end
            default: res.status = ST_INVALID;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 32; i++)
                rf_reg[i] <= '0;
        end
        else if (fire && wen && wrd != 5'd0)
            rf_reg[wrd] <= r;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_rd_reg   <= '0;
            pend_byte_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire && (in_uop.kind == K_LW || in_uop.kind == K_LBU))
            begin
                pend_rd_reg   <= in_uop.rd;
                pend_byte_reg <= (in_uop.kind == K_LBU);
            end
            else if (fire && in_uop.kind == K_LDRET)
                pend_rd_reg <= '0;
            if (fire)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
            out_reg <= res;
    end

`ifndef NO_ASSERTIONS
    a_x0_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rf_reg[0] == '0)
        else $error("x0 written");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> (out_valid_reg && $stable(out_reg)))
        else $error("result lost under stall");
    a_ldret_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && in_uop.kind == K_LDRET) |=> (pend_rd_reg == '0))
        else $error("pending load not cleared");
`endif

endmodule

// ===== hw/rtl/rv32i_subset_execute_step.sv =====
// Executes one RV32I-subset instruction (or one load-return word) per cycle
// while the output keeps up. A decode front end classifies each word into a
// two-entry queue; the execute back end reads the 32-entry register file,
// writes back and registers the result, so one word is accepted every cycle
// while the output keeps up. Each result passes through a queue entry and the
// execute output register. Loads only issue a read request; a later word with
// tuser=1 returns the data for the most recent pending load.
module rv32i_subset_execute_step (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [95:0]  s_axis_tdata,   // instruction, pc, load_data
    input  logic         s_axis_tuser,   // func
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [135:0] m_axis_tdata    // next_pc, mem_request, mem_address,
                                         // mem_bytes, mem_write_data, status,
                                         // exit_code, zero fill
);
    import rv32s_pkg::*;

    uop_t    dec_uop;
    uop_t    q_uop;
    logic    q_valid;
    logic    q_ready;
    result_t res;

    rv32s_decode u_decode (
        .func        (s_axis_tuser),
        .instruction (s_axis_tdata[31:0]),
        .pc          (s_axis_tdata[63:32]),
        .load_data   (s_axis_tdata[95:64]),
        .uop         (dec_uop)
    );

    rv32s_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_uop    (dec_uop),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_uop   (q_uop)
    );

    rv32s_execute u_execute (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (q_valid),
        .in_ready  (q_ready),
        .in_uop    (q_uop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (res)
    );

    assign m_axis_tdata = {1'b0, res.exit_code, res.status, res.mem_write_data,
                           res.mem_bytes, res.mem_address, res.mem_request,
                           res.next_pc};

endmodule
